// ----- sv/packet_duplicate_history_filter_macros.svh -----
// Assertion macros used by the duplicate filter checker
`ifndef PACKET_DUPLICATE_HISTORY_FILTER_MACROS_SVH
`define PACKET_DUPLICATE_HISTORY_FILTER_MACROS_SVH

// Implication checked on every rising clock edge outside reset
`define PDHF_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset
`define PDHF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/pdhf_pkg.sv -----
// Types and constants of the packet duplicate history filter
package pdhf_pkg;

    localparam int HISTORY_DEPTH_DEF = 16;

    // configuration port
    localparam int CFG_ADDR_W  = 4;
    localparam int CFG_DATA_W  = 32;
    localparam int REG_IDX_W   = 2;

    localparam logic [REG_IDX_W-1:0] REG_OWN_ADDRESS  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_DEST_ADDRESS = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_TIMEOUT_MS   = 2'd2;

    localparam logic [7:0]  OWN_ADDRESS_RST  = 8'd0;
    localparam logic [7:0]  DEST_ADDRESS_RST = 8'd255;
    localparam logic [31:0] TIMEOUT_MS_RST   = 32'd1000;
    localparam logic [7:0]  SEQ_COUNTER_RST  = 8'd255;

    localparam logic CMD_RECEIVE  = 1'b0;
    localparam logic CMD_TRANSMIT = 1'b1;

    // one history entry as held in the memory
    typedef struct packed {
        logic [7:0]  src;
        logic [7:0]  dst;
        logic [7:0]  seq;
        logic [3:0]  typ;
        logic [31:0] stamp;
    } entry_t;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SCAN  = 5'b00010,
        ST_DRAIN = 5'b00100,
        ST_WRITE = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

endpackage

// ----- sv/pdhf_stream_if.sv -----
// Request and response stream interfaces of the duplicate filter
interface pdhf_req_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [7:0]  pkt_from;
    logic [7:0]  pkt_to;
    logic [7:0]  pkt_seq;
    logic [7:0]  pkt_flags;
    logic [31:0] now_ms;

    modport source (output valid, cmd, pkt_from, pkt_to, pkt_seq, pkt_flags, now_ms,
                    input ready);
    modport sink (input valid, cmd, pkt_from, pkt_to, pkt_seq, pkt_flags, now_ms,
                  output ready);
endinterface

interface pdhf_rsp_if;
    logic       valid;
    logic       ready;
    logic       is_duplicate;
    logic [3:0] pkt_type;
    logic [7:0] tx_seq;

    modport source (output valid, is_duplicate, pkt_type, tx_seq, input ready);
    modport sink (input valid, is_duplicate, pkt_type, tx_seq, output ready);
endinterface

// ----- sv/packet_duplicate_history_filter.sv -----
// Duplicate packet suppression cache: history memory, scan sequencer, APB registers
//
// Each request is one packet header. A receive (cmd 0) is checked against the
// history: entries older than timeout_ms (age taken modulo 2^32) are dropped,
// and the lowest live entry equal in source, destination, sequence id and the
// low four flag bits is refreshed and reported as a duplicate; on a miss the
// header goes into the next ring slot. A transmit (cmd 1) bumps the 8-bit
// sequence counter and records own_address/dest_address with the new id.
// A request holds off the input from its transfer until its response is
// loaded, so a new request is taken only once the last one is through: the
// history memory has a single read port, so the expiry and match scan reads
// one entry a cycle, followed by a drain, a write-back and a result step.
// The result step waits while the output register still holds an untaken
// response; a new request can be taken while the latest response waits.
// Entry valid bits live in flip-flops, so the block is ready right after
// reset. Registers: own_address at 0x0, dest_address at 0x4, timeout_ms at
// 0x8; write them only while idle.
module packet_duplicate_history_filter
    import pdhf_pkg::*;
#(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    pdhf_req_if.sink              req,
    pdhf_rsp_if.source            rsp,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int IDX_W = $clog2(HISTORY_DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HISTORY_DEPTH - 1);

    // configuration registers
    logic [7:0]  own_addr_reg;
    logic [7:0]  dest_addr_reg;
    logic [31:0] timeout_reg;

    // control state
    state_t                   state_reg, state_next;
    logic [HISTORY_DEPTH-1:0] valid_reg, valid_next;
    logic [IDX_W-1:0]         ptr_reg, ptr_next;
    logic [7:0]               seq_cnt_reg, seq_cnt_next;
    logic [IDX_W-1:0]         scan_idx_reg, scan_idx_next;
    logic                     eval_vld_reg, eval_vld_next;
    logic [IDX_W-1:0]         eval_idx_reg, eval_idx_next;
    logic                     hit_reg, hit_next;
    logic [IDX_W-1:0]         hit_idx_reg, hit_idx_next;
    logic                     rsp_vld_reg, rsp_vld_next;

    // current item
    logic        cmd_reg, cmd_next;
    entry_t      hdr_reg, hdr_next;

    // response payload
    logic        dup_out_reg, dup_out_next;
    logic [3:0]  type_out_reg, type_out_next;
    logic [7:0]  seq_out_reg, seq_out_next;

    // history memory
    entry_t           hist_mem [HISTORY_DEPTH];
    entry_t           rd_data_reg;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    entry_t           mem_wdata;

    logic [IDX_W-1:0] ptr_inc;
    logic [31:0]      age;
    logic             ent_live;
    logic             ent_expired;
    logic             ent_match;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        case (paddr[CFG_ADDR_W-1:2])
            REG_OWN_ADDRESS:  prdata = {24'd0, own_addr_reg};
            REG_DEST_ADDRESS: prdata = {24'd0, dest_addr_reg};
            REG_TIMEOUT_MS:   prdata = timeout_reg;
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_addr_reg  <= OWN_ADDRESS_RST;
            dest_addr_reg <= DEST_ADDRESS_RST;
            timeout_reg   <= TIMEOUT_MS_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[CFG_ADDR_W-1:2])
                REG_OWN_ADDRESS:  own_addr_reg  <= pwdata[7:0];
                REG_DEST_ADDRESS: dest_addr_reg <= pwdata[7:0];
                REG_TIMEOUT_MS:   timeout_reg   <= pwdata;
                default:          ;
            endcase
        end
    end

    assign req.ready        = (state_reg == ST_IDLE);
    assign rsp.valid        = rsp_vld_reg;
    assign rsp.is_duplicate = dup_out_reg;
    assign rsp.pkt_type     = type_out_reg;
    assign rsp.tx_seq       = seq_out_reg;

    assign ptr_inc = (ptr_reg == LAST_IDX) ? '0 : ptr_reg + 1'b1;

    // entry read last cycle, checked this cycle
    assign age         = hdr_reg.stamp - rd_data_reg.stamp;
    assign ent_live    = eval_vld_reg && valid_reg[eval_idx_reg];
    assign ent_expired = ent_live && (age > timeout_reg);
    assign ent_match   = ent_live && !ent_expired && (cmd_reg == CMD_RECEIVE)
                         && (rd_data_reg.src == hdr_reg.src)
                         && (rd_data_reg.dst == hdr_reg.dst)
                         && (rd_data_reg.seq == hdr_reg.seq)
                         && (rd_data_reg.typ == hdr_reg.typ);

    always_comb
    begin
        state_next    = state_reg;
        valid_next    = valid_reg;
        ptr_next      = ptr_reg;
        seq_cnt_next  = seq_cnt_reg;
        scan_idx_next = scan_idx_reg;
        eval_vld_next = eval_vld_reg;
        eval_idx_next = eval_idx_reg;
        hit_next      = hit_reg;
        hit_idx_next  = hit_idx_reg;
        rsp_vld_next  = rsp_vld_reg;
        cmd_next      = cmd_reg;
        hdr_next      = hdr_reg;
        dup_out_next  = dup_out_reg;
        type_out_next = type_out_reg;
        seq_out_next  = seq_out_reg;
        mem_we        = 1'b0;
        mem_waddr     = ptr_inc;
        mem_wdata     = hdr_reg;

        if (rsp.valid && rsp.ready)
        begin
            rsp_vld_next = 1'b0;
        end

        if (ent_expired)
        begin
            valid_next[eval_idx_reg] = 1'b0;
        end
        if (ent_match && !hit_reg)
        begin
            hit_next     = 1'b1;
            hit_idx_next = eval_idx_reg;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    cmd_next       = req.cmd;
                    hdr_next.typ   = req.pkt_flags[3:0];
                    hdr_next.stamp = req.now_ms;
                    if (req.cmd == CMD_TRANSMIT)
                    begin
                        seq_cnt_next = seq_cnt_reg + 8'd1;
                        hdr_next.src = own_addr_reg;
                        hdr_next.dst = dest_addr_reg;
                        hdr_next.seq = seq_cnt_reg + 8'd1;
                    end
                    else
                    begin
                        hdr_next.src = req.pkt_from;
                        hdr_next.dst = req.pkt_to;
                        hdr_next.seq = req.pkt_seq;
                    end
                    hit_next      = 1'b0;
                    scan_idx_next = '0;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                eval_vld_next = 1'b1;
                eval_idx_next = scan_idx_reg;
                if (scan_idx_reg == LAST_IDX)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                eval_vld_next = 1'b0;
                state_next    = ST_WRITE;
            end
            ST_WRITE:
            begin
                // a hit rewrites the same header with a fresh stamp
                mem_we = 1'b1;
                if (hit_reg)
                begin
                    mem_waddr = hit_idx_reg;
                end
                else
                begin
                    ptr_next = ptr_inc;
                end
                valid_next[mem_waddr] = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!rsp_vld_reg || rsp.ready)
                begin
                    rsp_vld_next  = 1'b1;
                    dup_out_next  = hit_reg;
                    type_out_next = hdr_reg.typ;
                    seq_out_next  = seq_cnt_reg;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            valid_reg    <= '0;
            ptr_reg      <= LAST_IDX;
            seq_cnt_reg  <= SEQ_COUNTER_RST;
            scan_idx_reg <= '0;
            eval_vld_reg <= 1'b0;
            eval_idx_reg <= '0;
            hit_reg      <= 1'b0;
            hit_idx_reg  <= '0;
            rsp_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            valid_reg    <= valid_next;
            ptr_reg      <= ptr_next;
            seq_cnt_reg  <= seq_cnt_next;
            scan_idx_reg <= scan_idx_next;
            eval_vld_reg <= eval_vld_next;
            eval_idx_reg <= eval_idx_next;
            hit_reg      <= hit_next;
            hit_idx_reg  <= hit_idx_next;
            rsp_vld_reg  <= rsp_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        hdr_reg      <= hdr_next;
        dup_out_reg  <= dup_out_next;
        type_out_reg <= type_out_next;
        seq_out_reg  <= seq_out_next;
    end

    // read data is used only in the scan and the drain, writes come only after them: no overlap
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            hist_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= hist_mem[scan_idx_reg];
    end

endmodule

// ----- sv/pdhf_checker.sv -----
// Port-level checker for the duplicate filter, bound to the top level
`include "packet_duplicate_history_filter_macros.svh"

module pdhf_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_ready,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic       rsp_is_duplicate,
    input logic [3:0] rsp_pkt_type,
    input logic [7:0] rsp_tx_seq,
    input logic       pready
);

    `PDHF_ASSERT_IMPL(a_pready_high, clk, rst_n, 1'b1, pready, "pready dropped")
    // one request in work at a time
    `PDHF_ASSERT_NEXT(a_busy_after_req, clk, rst_n, req_valid && req_ready, !req_ready, "request taken while busy")
    // the scan lies between a request and its response, so a response never follows a request at once
    `PDHF_ASSERT_NEXT(a_no_instant_rsp, clk, rst_n, req_valid && req_ready, !$rose(rsp_valid), "response came too early")
    `PDHF_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_is_duplicate) && $stable(rsp_pkt_type) && $stable(rsp_tx_seq), "stalled response changed")

endmodule

bind packet_duplicate_history_filter pdhf_checker u_pdhf_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .req_valid        (req.valid),
    .req_ready        (req.ready),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_is_duplicate (rsp.is_duplicate),
    .rsp_pkt_type     (rsp.pkt_type),
    .rsp_tx_seq       (rsp.tx_seq),
    .pready           (pready)
);
